>>> hdl/rc3_pkg.sv
package rc3_pkg;

   localparam int CH_W = 8;
   localparam int PIX_W = 3 * CH_W;
   localparam int COEF_W = 12;
   localparam int KROW_W = 3 * COEF_W;
   localparam int DIM_W = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = KROW_W;
   localparam int PROD_W = 20;
   localparam int RSUM_W = 22;
   localparam int SUM_W = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_TOP = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_MIDDLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_BOTTOM = 3'd4;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET = 11'd640;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 11'd480;
   localparam logic [KROW_W-1:0] KERNEL_TOP_RESET = 36'h0_0000_0000;
   localparam logic [KROW_W-1:0] KERNEL_MIDDLE_RESET = 36'h0_0010_0000;
   localparam logic [KROW_W-1:0] KERNEL_BOTTOM_RESET = 36'h0_0000_0000;

   localparam logic [CH_W-1:0] CH_MAX = 8'd255;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_pair_type;

   typedef pixel_type [2:0][2:0] window_type;

   typedef logic [2:0][KROW_W-1:0] kernel_type;

   typedef struct packed {
      logic started;
      logic no_top;
      logic no_bottom;
      logic no_left;
      logic no_right;
      logic end_of_line;
      logic end_of_frame;
   } position_type;

   typedef struct packed {
      logic end_of_line;
      logic end_of_frame;
   } marks_type;

endpackage

>>> hdl/rc3_raster_ctrl.sv
module rc3_raster_ctrl #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [rc3_pkg::DIM_W-1:0]     frame_width,
   input  logic [rc3_pkg::DIM_W-1:0]     frame_height,
   output logic [$clog2(MAX_WIDTH)-1:0]  col,
   output rc3_pkg::position_type         pos
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam logic [1:0] ROW_FULL = 2'd2;
   localparam logic [1:0] ROW_ONE = 2'd1;

   logic [CW:0]   width_lim;
   logic [RW:0]   height_lim;
   logic [CW-1:0] in_col_ff, in_col_in, in_col_cur;
   logic [CW-1:0] out_col_ff, out_col_in, out_col_cur;
   logic [1:0]    in_row_ff, in_row_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic          last_col, last_row, line_end, frame_end, started;

   always_comb begin
      if (frame_width == '0) begin
         width_lim = (CW+1)'(1);
      end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
         width_lim = (CW+1)'(MAX_WIDTH);
      end else begin
         width_lim = (CW+1)'(frame_width);
      end
      if (frame_height == '0) begin
         height_lim = (RW+1)'(1);
      end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
         height_lim = (RW+1)'(MAX_HEIGHT);
      end else begin
         height_lim = (RW+1)'(frame_height);
      end
   end

   always_comb begin
      in_col_cur = ({1'b0, in_col_ff} >= width_lim) ? '0 : in_col_ff;
      out_col_cur = ({1'b0, out_col_ff} >= width_lim) ? '0 : out_col_ff;
      last_col = ({1'b0, in_col_cur} + 1'b1) >= width_lim;
      line_end = ({1'b0, out_col_cur} + 1'b1) >= width_lim;
      last_row = ({1'b0, out_row_ff} + 1'b1) >= height_lim;
      frame_end = line_end && last_row;
      started = (in_row_ff == ROW_FULL) || (in_row_ff == ROW_ONE && in_col_cur != '0);

      in_col_in = last_col ? '0 : in_col_cur + 1'b1;
      in_row_in = (last_col && in_row_ff != ROW_FULL) ? in_row_ff + 2'd1 : in_row_ff;
      out_col_in = out_col_cur;
      out_row_in = out_row_ff;
      if (started) begin
         if (frame_end) begin
            in_col_in = '0;
            in_row_in = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (line_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_cur + 1'b1;
         end
      end
   end

   always_comb begin
      col = in_col_cur;
      pos.started = started;
      pos.no_top = (out_row_ff == '0);
      pos.no_bottom = last_row;
      pos.no_left = (out_col_cur == '0);
      pos.no_right = line_end;
      pos.end_of_line = line_end;
      pos.end_of_frame = frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (step) begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   a_frame_end_restarts: assert property (@(posedge clock) disable iff (reset)
      step && started && frame_end |=>
         (in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("Counters not restarted after the last pixel of a frame.");

   a_idle_counters_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(out_row_ff) && $stable(in_row_ff))
      else $error("Row counters moved without an input transfer.");

endmodule

>>> hdl/rc3_line_window.sv
module rc3_line_window #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [$clog2(MAX_WIDTH)-1:0]  col,
   input  rc3_pkg::pixel_type            pixel,
   input  rc3_pkg::position_type         pos,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rc3_pkg::window_type           window,
   output rc3_pkg::marks_type            marks
);

   localparam int CW = $clog2(MAX_WIDTH);

   rc3_pkg::line_pair_type line_mem [MAX_WIDTH];

   rc3_pkg::line_pair_type rd_ff, fwd_ff, cur_pair, wr_pair;
   logic                   s1_valid_ff, s1_hit_ff;
   logic [CW-1:0]          s1_col_ff;
   rc3_pkg::pixel_type     s1_pix_ff;
   rc3_pkg::position_type  s1_pos_ff;
   rc3_pkg::window_type    window_ff, window_in, masked;
   logic                   s2_valid_ff;
   rc3_pkg::window_type    s2_window_ff;
   rc3_pkg::marks_type     s2_marks_ff;
   logic                   accept, s1_fire;

   assign in_ready = !s1_valid_ff || !s1_pos_ff.started || out_ready;
   assign accept = in_valid && in_ready;
   assign s1_fire = s1_valid_ff && in_ready;

   // The entry written in this cycle is not yet visible to a read of the same address.
   assign cur_pair = s1_hit_ff ? fwd_ff : rd_ff;

   always_comb begin
      wr_pair.upper = cur_pair.middle;
      wr_pair.middle = s1_pix_ff;
      for (int r = 0; r < 3; r++) begin
         window_in[r][0] = window_ff[r][1];
         window_in[r][1] = window_ff[r][2];
      end
      window_in[0][2] = cur_pair.upper;
      window_in[1][2] = cur_pair.middle;
      window_in[2][2] = s1_pix_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((r == 0 && s1_pos_ff.no_top) || (r == 2 && s1_pos_ff.no_bottom) ||
                (c == 0 && s1_pos_ff.no_left) || (c == 2 && s1_pos_ff.no_right)) begin
               masked[r][c] = '0;
            end else begin
               masked[r][c] = window_in[r][c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col];
      end
      if (s1_fire) begin
         line_mem[s1_col_ff] <= wr_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_hit_ff <= 1'b0;
         window_ff <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (accept) begin
            s1_hit_ff <= s1_fire && (s1_col_ff == col);
         end
         if (s1_fire) begin
            window_ff <= window_in;
         end
         if (out_ready) begin
            s2_valid_ff <= s1_fire && s1_pos_ff.started;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff <= col;
         s1_pix_ff <= pixel;
         s1_pos_ff <= pos;
      end
      if (s1_fire) begin
         fwd_ff <= wr_pair;
      end
      if (out_ready) begin
         s2_window_ff <= masked;
         s2_marks_ff.end_of_line <= s1_pos_ff.end_of_line;
         s2_marks_ff.end_of_frame <= s1_pos_ff.end_of_frame;
      end
   end

   assign out_valid = s2_valid_ff;
   assign window = s2_window_ff;
   assign marks = s2_marks_ff;

   a_window_moves_on_transfer: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(window_ff))
      else $error("Window shifted without a stage transfer.");

   a_forward_on_same_entry: assert property (@(posedge clock) disable iff (reset)
      accept && s1_fire && (s1_col_ff == col) |=> s1_hit_ff)
      else $error("Back-to-back access to one line entry not forwarded.");

endmodule

>>> hdl/rc3_filter_pipe.sv
module rc3_filter_pipe #(
   parameter int COEF_FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          win_valid,
   output logic                          win_ready,
   input  rc3_pkg::window_type           window,
   input  rc3_pkg::marks_type            marks,
   input  rc3_pkg::kernel_type           kernel,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rc3_pkg::pixel_type            out_pixel,
   output rc3_pkg::marks_type            out_marks
);

   localparam int PW = rc3_pkg::PROD_W;
   localparam int RSW = rc3_pkg::RSUM_W;
   localparam int SW = rc3_pkg::SUM_W;
   localparam int CHW = rc3_pkg::CH_W;
   localparam int CFW = rc3_pkg::COEF_W;

   logic signed [PW-1:0]  prod_in [3][3][3];
   logic signed [PW-1:0]  prod_ff [3][3][3];
   logic signed [RSW-1:0] rsum_in [3][3];
   logic signed [RSW-1:0] rsum_ff [3][3];
   logic [CHW-1:0]        chan_in [3];
   rc3_pkg::pixel_type    out_pixel_ff;
   rc3_pkg::marks_type    prod_marks_ff, rsum_marks_ff, out_marks_ff;
   logic                  prod_valid_ff, rsum_valid_ff, out_valid_ff;
   logic                  prod_ena, rsum_ena, out_ena;

   assign out_ena = !out_valid_ff || out_ready;
   assign rsum_ena = !rsum_valid_ff || out_ena;
   assign prod_ena = !prod_valid_ff || rsum_ena;
   assign win_ready = prod_ena;

   // Kernel entry (r, s) weights window position (2 - r, 2 - s).
   always_comb begin
      logic signed [CFW-1:0] coef;
      logic signed [CHW:0]   pel;
      for (int ch = 0; ch < 3; ch++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               coef = signed'(kernel[2-r][CFW*(2-c) +: CFW]);
               pel = signed'({1'b0, window[r][c][CHW*ch +: CHW]});
               prod_in[ch][r][c] = PW'(coef * pel);
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int r = 0; r < 3; r++) begin
            rsum_in[ch][r] = RSW'(prod_ff[ch][r][0]) + RSW'(prod_ff[ch][r][1]) +
                             RSW'(prod_ff[ch][r][2]);
         end
      end
   end

   always_comb begin
      logic signed [SW-1:0] total;
      logic signed [SW-1:0] scaled;
      for (int ch = 0; ch < 3; ch++) begin
         total = SW'(rsum_ff[ch][0]) + SW'(rsum_ff[ch][1]) + SW'(rsum_ff[ch][2]);
         scaled = total >>> COEF_FRAC_BITS;
         if (total < 0) begin
            chan_in[ch] = '0;
         end else if (scaled > $signed(SW'(rc3_pkg::CH_MAX))) begin
            chan_in[ch] = rc3_pkg::CH_MAX;
         end else begin
            chan_in[ch] = scaled[CHW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (prod_ena) begin
            prod_valid_ff <= win_valid;
         end
         if (rsum_ena) begin
            rsum_valid_ff <= prod_valid_ff;
         end
         if (out_ena) begin
            out_valid_ff <= rsum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ena) begin
         prod_ff <= prod_in;
         prod_marks_ff <= marks;
      end
      if (rsum_ena) begin
         rsum_ff <= rsum_in;
         rsum_marks_ff <= prod_marks_ff;
      end
      if (out_ena) begin
         out_pixel_ff.red <= chan_in[0];
         out_pixel_ff.green <= chan_in[1];
         out_pixel_ff.blue <= chan_in[2];
         out_marks_ff <= rsum_marks_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;
   assign out_marks = out_marks_ff;

   a_stall_keeps_items: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready && rsum_valid_ff |=> rsum_valid_ff && out_valid_ff)
      else $error("Pipeline item lost while the result was stalled.");

endmodule

>>> hdl/rgb_convolution_3x3_unit.sv
// Throughput: one pixel per clock cycle unless rsp_tready stalls the output; the line store
// memory is read and written once per item. A result's window is complete with the item
// frame_width + 1 items after its own pixel, so frame_width + 1 flush items end a frame; from
// that transfer the result passes the s1, s2, prod, rsum and out registers to the output.
// Reset: synchronous; clears counters, window, valid bits; CSRs to defaults; line store not cleared.
module rgb_convolution_3x3_unit #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COEF_FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rc3_pkg::PIX_W-1:0]           req_tdata,  // red_in, green_in, blue_in
   input  logic                                req_tuser,  // command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rc3_pkg::PIX_W-1:0]           rsp_tdata,  // red_out, green_out, blue_out
   output logic                                rsp_tlast,  // end_of_line
   output logic                                rsp_tuser,  // end_of_frame
   input  logic                                csr_we,
   input  logic [rc3_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rc3_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [rc3_pkg::DIM_W-1:0] frame_width_ff, frame_height_ff;
   rc3_pkg::kernel_type       kernel_ff;
   logic                      accept, win_valid, win_ready;
   logic [CW-1:0]             col;
   rc3_pkg::position_type     pos;
   rc3_pkg::pixel_type        pixel, out_pixel;
   rc3_pkg::window_type       window;
   rc3_pkg::marks_type        marks, out_marks;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= rc3_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= rc3_pkg::FRAME_HEIGHT_RESET;
         kernel_ff[0] <= rc3_pkg::KERNEL_TOP_RESET;
         kernel_ff[1] <= rc3_pkg::KERNEL_MIDDLE_RESET;
         kernel_ff[2] <= rc3_pkg::KERNEL_BOTTOM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rc3_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[rc3_pkg::DIM_W-1:0];
            end
            rc3_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[rc3_pkg::DIM_W-1:0];
            end
            rc3_pkg::CSR_KERNEL_TOP: begin
               kernel_ff[0] <= csr_wdata;
            end
            rc3_pkg::CSR_KERNEL_MIDDLE: begin
               kernel_ff[1] <= csr_wdata;
            end
            rc3_pkg::CSR_KERNEL_BOTTOM: begin
               kernel_ff[2] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign accept = req_tvalid && req_tready;
   assign pixel = req_tuser ? '0 : rc3_pkg::pixel_type'(req_tdata);

   rc3_raster_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_raster_ctrl (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .col          (col),
      .pos          (pos)
   );

   rc3_line_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .col       (col),
      .pixel     (pixel),
      .pos       (pos),
      .out_valid (win_valid),
      .out_ready (win_ready),
      .window    (window),
      .marks     (marks)
   );

   rc3_filter_pipe #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_filter_pipe (
      .clock     (clock),
      .reset     (reset),
      .win_valid (win_valid),
      .win_ready (win_ready),
      .window    (window),
      .marks     (marks),
      .kernel    (kernel_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (out_pixel),
      .out_marks (out_marks)
   );

   assign rsp_tdata = out_pixel;
   assign rsp_tlast = out_marks.end_of_line;
   assign rsp_tuser = out_marks.end_of_frame;

endmodule
